[rtl/srg_pkg.sv]
// ----------------------------------------------------------------------------
// Stepper ramp step generator package
// Command codes, fixed field widths and the controller-to-datapath command set.
// ----------------------------------------------------------------------------
package srg_pkg;

  localparam int unsigned RAMP_WIDTH = 19;
  localparam logic [RAMP_WIDTH-1:0] RAMP_RESET = 19'd16;

  // 1 step/s in 1/16 step/s units
  localparam int unsigned SPEED_FRAC = 16;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_US_TICK = 2'd0;
  localparam cmd_t CMD_RAMP    = 2'd1;
  localparam cmd_t CMD_TARGET  = 2'd2;

  typedef struct packed {
    logic tick;        // microsecond tick accepted
    logic set_target;  // new target accepted
    logic ramp;        // control tick accepted, move command speed
    logic div_init;    // load divider operands
    logic div_step;    // one quotient bit
    logic div_done;    // write step interval
    logic out_load;    // capture result beat
  } ctrl_t;

endpackage

[rtl/srg_in_if.sv]
// ----------------------------------------------------------------------------
// Stepper ramp input channel
// Valid/ready channel carrying a command and a target speed.
// ----------------------------------------------------------------------------
interface srg_in_if #(
  parameter int SPEED_WIDTH = 20
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic signed [SPEED_WIDTH-1:0] goal_speed;

  modport source (output valid, output cmd, output goal_speed, input ready);
  modport sink   (input valid, input cmd, input goal_speed, output ready);
endinterface

[rtl/srg_out_if.sv]
// ----------------------------------------------------------------------------
// Stepper ramp output channel
// Valid/ready channel carrying step fire, direction and command speed.
// ----------------------------------------------------------------------------
interface srg_out_if #(
  parameter int SPEED_WIDTH = 20
);
  logic                          valid;
  logic                          ready;
  logic                          step_fire;
  logic                          direction;
  logic signed [SPEED_WIDTH-1:0] command_speed_out;

  modport source (output valid, output step_fire, output direction,
                  output command_speed_out, input ready);
  modport sink   (input valid, input step_fire, input direction,
                  input command_speed_out, output ready);
endinterface

[rtl/srg_ctrl.sv]
// ----------------------------------------------------------------------------
// Stepper ramp controller
// Sequences accept, interval divide and result beat; owns the output valid.
// ----------------------------------------------------------------------------
module srg_ctrl
  import srg_pkg::*;
#(
  parameter int unsigned DIV_STEPS = 24
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  cmd_t  in_cmd_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output ctrl_t ctrl_o
);

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctrl_o            = '0;
    ctrl_o.tick       = accept && (in_cmd_i == CMD_US_TICK);
    ctrl_o.set_target = accept && (in_cmd_i == CMD_TARGET);
    ctrl_o.ramp       = accept && (in_cmd_i == CMD_RAMP);
    ctrl_o.div_init   = (state_q == ST_LOAD);
    ctrl_o.div_step   = (state_q == ST_DIV);
    ctrl_o.div_done   = (state_q == ST_DONE);
    ctrl_o.out_load   = (accept && (in_cmd_i != CMD_RAMP)) || (state_q == ST_DONE);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (ctrl_o.ramp) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = ST_DIV;
        cnt_d   = CNT_W'(DIV_STEPS - 1);
      end
      ST_DIV: begin
        if (cnt_q == '0) state_d = ST_DONE;
        else cnt_d = cnt_q - 1'b1;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // hold the beat until the sink takes it
  always_comb begin
    priority if (ctrl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/srg_dp.sv]
// ----------------------------------------------------------------------------
// Stepper ramp datapath
// Speed ramp, restoring interval divider, elapsed counter and result register.
// ----------------------------------------------------------------------------
module srg_dp
  import srg_pkg::*;
#(
  parameter int unsigned SPEED_WIDTH      = 20,
  parameter int unsigned TICKS_PER_SECOND = 1000000,
  parameter int unsigned DIVD_W           = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [RAMP_WIDTH-1:0]         cfg_wdata_i,
  input  ctrl_t                         ctrl_i,
  input  logic signed [SPEED_WIDTH-1:0] target_i,
  output logic                          fire_o,
  output logic                          dir_o,
  output logic signed [SPEED_WIDTH-1:0] spd_o
);

  localparam int unsigned SW       = SPEED_WIDTH;
  localparam int unsigned SUM_W    = ((SW > RAMP_WIDTH) ? SW : RAMP_WIDTH) + 2;
  localparam int unsigned QX_W     = DIVD_W + SW;
  localparam longint unsigned DIVIDEND = 64'(SPEED_FRAC) * 64'(TICKS_PER_SECOND);
  localparam logic [SW-1:0]        SPD_ALL  = '1;
  localparam logic signed [SW-1:0] SPD_MIN  = SW'(SPEED_FRAC);
  localparam logic signed [SW-1:0] SPD_NMIN = -SPD_MIN;

  logic signed [SW-1:0] cmd_spd_q, cmd_spd_d;
  logic signed [SW-1:0] tgt_q, tgt_d;
  logic [SW-1:0]        intv_q, intv_d;
  logic [SW-1:0]        elap_q, elap_d;
  logic                 dir_q, dir_d;
  logic [RAMP_WIDTH-1:0] ramp_q;

  logic [SW-1:0]     mag_q;
  logic              small_q;
  logic [SW-1:0]     rem_q;
  logic [DIVD_W-1:0] dvd_q;
  logic [DIVD_W-1:0] quo_q;

  logic                 out_fire_q;
  logic                 out_dir_q;
  logic signed [SW-1:0] out_spd_q;

  // ramp toward the target, clamped at it
  logic signed [SUM_W-1:0] cs_w, tg_w, d_w, up_w, dn_w, ramp_w;

  always_comb begin
    cs_w = SUM_W'(cmd_spd_q);
    tg_w = SUM_W'(tgt_q);
    d_w  = signed'(SUM_W'(ramp_q));
    up_w = cs_w + d_w;
    dn_w = cs_w - d_w;
    priority if (cs_w < tg_w) begin
      ramp_w = (up_w > tg_w) ? tg_w : up_w;
    end else if (cs_w > tg_w) begin
      ramp_w = (dn_w < tg_w) ? tg_w : dn_w;
    end else begin
      ramp_w = cs_w;
    end
  end

  // magnitude of the command speed for the divider
  logic [SW-1:0] mag_d;
  assign mag_d = cmd_spd_q[SW-1] ? SW'(-cmd_spd_q) : SW'(cmd_spd_q);

  // one restoring divide step
  logic [SW:0]   rem_sh;
  logic          rem_ge;
  logic [SW-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[DIVD_W-1]};
    rem_ge  = rem_sh >= {1'b0, mag_q};
    rem_nxt = rem_ge ? SW'(rem_sh - {1'b0, mag_q}) : SW'(rem_sh);
  end

  // saturate the quotient to the interval width
  logic [QX_W-1:0] quo_x;
  logic [SW-1:0]   quo_sat;

  always_comb begin
    quo_x   = QX_W'(quo_q);
    quo_sat = (quo_x > QX_W'(SPD_ALL)) ? SPD_ALL : SW'(quo_x);
  end

  // microsecond tick
  logic [SW-1:0] elap_inc;
  logic          active;
  logic          fire;

  always_comb begin
    elap_inc = (&elap_q) ? elap_q : elap_q + 1'b1;
    active   = (cmd_spd_q >= SPD_MIN) || (cmd_spd_q <= SPD_NMIN);
    fire     = active && (elap_inc >= intv_q);
  end

  always_comb begin
    cmd_spd_d = cmd_spd_q;
    tgt_d     = tgt_q;
    intv_d    = intv_q;
    elap_d    = elap_q;
    dir_d     = dir_q;
    if (ctrl_i.tick) begin
      elap_d = fire ? '0 : elap_inc;
      if (active) dir_d = cmd_spd_q[SW-1];
    end
    if (ctrl_i.set_target) tgt_d = target_i;
    if (ctrl_i.ramp) cmd_spd_d = SW'(ramp_w);
    if (ctrl_i.div_done) intv_d = small_q ? SPD_ALL : quo_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_spd_q <= '0;
      tgt_q     <= '0;
      intv_q    <= SPD_ALL;
      elap_q    <= '0;
      dir_q     <= 1'b0;
      ramp_q    <= RAMP_RESET;
    end else begin
      cmd_spd_q <= cmd_spd_d;
      tgt_q     <= tgt_d;
      intv_q    <= intv_d;
      elap_q    <= elap_d;
      dir_q     <= dir_d;
      if (cfg_we_i) ramp_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_init) begin
      mag_q   <= mag_d;
      small_q <= mag_d < SW'(SPEED_FRAC);
      rem_q   <= '0;
      dvd_q   <= DIVD_W'(DIVIDEND);
      quo_q   <= '0;
    end else if (ctrl_i.div_step) begin
      rem_q <= rem_nxt;
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[DIVD_W-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_fire_q <= ctrl_i.tick && fire;
      out_dir_q  <= dir_d;
      out_spd_q  <= cmd_spd_q;
    end
  end

  assign fire_o = out_fire_q;
  assign dir_o  = out_dir_q;
  assign spd_o  = out_spd_q;

endmodule

[rtl/stepper_ramp_step_generator_top.sv]
// ----------------------------------------------------------------------------
// Stepper ramp step generator
// Trapezoidal speed ramp with step interval divider and step pulse timing.
// ----------------------------------------------------------------------------
// Timing: microsecond tick, target write and unused command give their beat
//   in the cycle after accept; a control tick passes through the load, divide
//   and done states of the one-bit-per-cycle interval divider before its beat.
// Occupancy: one item in flight at a time.
// Reset: asynchronous, active low; speeds and counter clear, interval all ones.
module stepper_ramp_step_generator_top
  import srg_pkg::*;
#(
  parameter int unsigned SPEED_WIDTH      = 20,
  parameter int unsigned TICKS_PER_SECOND = 1000000
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [RAMP_WIDTH-1:0] cfg_wdata_i,
  srg_in_if.sink                in_ch_i,
  srg_out_if.source             out_ch_o
);

  localparam longint unsigned DIVIDEND = 64'(SPEED_FRAC) * 64'(TICKS_PER_SECOND);
  localparam int unsigned     DIVD_W   = $clog2(DIVIDEND + 1);

  ctrl_t ctrl;

  srg_ctrl #(
    .DIV_STEPS (DIVD_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .in_cmd_i    (in_ch_i.cmd),
    .in_ready_o  (in_ch_i.ready),
    .out_valid_o (out_ch_o.valid),
    .out_ready_i (out_ch_o.ready),
    .ctrl_o      (ctrl)
  );

  srg_dp #(
    .SPEED_WIDTH      (SPEED_WIDTH),
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .DIVD_W           (DIVD_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (ctrl),
    .target_i    (in_ch_i.goal_speed),
    .fire_o      (out_ch_o.step_fire),
    .dir_o       (out_ch_o.direction),
    .spd_o       (out_ch_o.command_speed_out)
  );

endmodule
